[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define YG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define YG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ygbd_pkg.sv]
// ----------------------------------------------------------------------------
// ygbd_pkg
// Types, constants and sigmoid helpers of the grid box decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ygbd_pkg;

    // Image and class limits
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 640;
    localparam int NUM_CLASSES  = 80;

    // Field widths
    localparam int LOGIT_W  = 16;
    localparam int COORD_W  = 12;
    localparam int SCORE_W  = 16;
    localparam int LABEL_W  = 8;
    localparam int GRID_W   = 8;
    localparam int PICK_W   = 2;
    localparam int STRIDE_W = 7;
    localparam int ANCHOR_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Logit lanes
    localparam int NUM_LOGITS = 6;
    localparam int LG_X   = 0;
    localparam int LG_Y   = 1;
    localparam int LG_W   = 2;
    localparam int LG_H   = 3;
    localparam int LG_OBJ = 4;
    localparam int LG_CLS = 5;

    // Anchor selector codes
    localparam logic [PICK_W-1:0] PICK_A    = 2'd0;
    localparam logic [PICK_W-1:0] PICK_B    = 2'd1;
    localparam logic [PICK_W-1:0] PICK_C    = 2'd2;
    localparam logic [PICK_W-1:0] PICK_NONE = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STRIDE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_WIDTH_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_WIDTH_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_WIDTH_C  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_HEIGHT_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_HEIGHT_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_HEIGHT_C = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd7;

    // Register reset values
    localparam logic [STRIDE_W-1:0] RST_GRID_STRIDE     = 7'd8;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR_WIDTH_A  = 10'd10;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR_WIDTH_B  = 10'd16;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR_WIDTH_C  = 10'd33;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR_HEIGHT_A = 10'd13;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR_HEIGHT_B = 10'd30;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR_HEIGHT_C = 10'd23;
    localparam logic [SCORE_W-1:0]  RST_SCORE_THRESHOLD = 16'd16384;

    // One half in Q0.16, used for rounding and the -0.5 centre offset
    localparam logic [15:0] HALF_Q16 = 16'd32768;

    // Table sigmoid operands of one logit, ready for interpolation
    typedef struct packed {
        logic        neg;
        logic [15:0] base;
        logic [11:0] diff;
        logic [9:0]  frac;
    } t_sig_pre;

    // round(65536*sig(k/4)), k = 0..32
    function automatic logic [15:0] sig_lut(input logic [5:0] k);
        logic [15:0] v;
        case (k)
            6'd0:    v = 16'd32768;
            6'd1:    v = 16'd36843;
            6'd2:    v = 16'd40793;
            6'd3:    v = 16'd44511;
            6'd4:    v = 16'd47911;
            6'd5:    v = 16'd50941;
            6'd6:    v = 16'd53581;
            6'd7:    v = 16'd55834;
            6'd8:    v = 16'd57724;
            6'd9:    v = 16'd59287;
            6'd10:   v = 16'd60565;
            6'd11:   v = 16'd61598;
            6'd12:   v = 16'd62428;
            6'd13:   v = 16'd63090;
            6'd14:   v = 16'd63615;
            6'd15:   v = 16'd64030;
            6'd16:   v = 16'd64357;
            6'd17:   v = 16'd64614;
            6'd18:   v = 16'd64816;
            6'd19:   v = 16'd64974;
            6'd20:   v = 16'd65097;
            6'd21:   v = 16'd65194;
            6'd22:   v = 16'd65269;
            6'd23:   v = 16'd65328;
            6'd24:   v = 16'd65374;
            6'd25:   v = 16'd65410;
            6'd26:   v = 16'd65438;
            6'd27:   v = 16'd65459;
            6'd28:   v = 16'd65476;
            6'd29:   v = 16'd65489;
            6'd30:   v = 16'd65500;
            6'd31:   v = 16'd65508;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

    // Magnitude, table lookup and slope of one Q4.12 logit
    function automatic t_sig_pre sig_front(input logic [LOGIT_W-1:0] raw);
        t_sig_pre    p;
        logic [16:0] mag;
        logic [5:0]  k;
        logic [15:0] lo_v;
        logic [15:0] hi_v;
        p.neg = raw[15];
        mag   = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        k     = {1'b0, mag[14:10]};
        lo_v  = sig_lut(k);
        hi_v  = sig_lut(k + 6'd1);
        // saturate at eight: last table entry, no slope
        if (mag[16] || mag[15]) begin
            p.base = sig_lut(6'd32);
            p.diff = '0;
            p.frac = '0;
        end else begin
            p.base = lo_v;
            p.diff = 12'(hi_v - lo_v);
            p.frac = mag[9:0];
        end
        return p;
    endfunction

    // Rounded interpolation and mirror for negative logits, Q0.16
    function automatic logic [15:0] sig_back(input t_sig_pre p);
        logic [21:0] prod;
        logic [22:0] rnd;
        logic [15:0] v;
        prod = p.diff * p.frac;
        rnd  = {1'b0, prod} + 23'd512;
        v    = p.base + {3'b0, rnd[22:10]};
        return p.neg ? 16'(17'h10000 - {1'b0, v}) : v;
    endfunction

    // Floor of a Q.32 value, clamped to [0, limit]
    function automatic logic [COORD_W-1:0] corner(input logic signed [50:0] q,
                                                  input logic [COORD_W-1:0] limit);
        logic [18:0] whole;
        logic [COORD_W-1:0] c;
        whole = q[50:32];
        if (q[50]) begin
            c = '0;
        end else if (whole > {7'b0, limit}) begin
            c = limit;
        end else begin
            c = whole[COORD_W-1:0];
        end
        return c;
    endfunction

endpackage

[sv/yolo_grid_box_decode.sv]
// ----------------------------------------------------------------------------
// yolo_grid_box_decode: five-stage pipeline; throughput one candidate per
// cycle while the output is not stalled; empty stages close up under output
// stall. Sync active-low reset clears stage valids and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yolo_grid_box_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // candidate input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ygbd_pkg::LOGIT_W-1:0] i_logit_x,
    input  logic signed [ygbd_pkg::LOGIT_W-1:0] i_logit_y,
    input  logic signed [ygbd_pkg::LOGIT_W-1:0] i_logit_w,
    input  logic signed [ygbd_pkg::LOGIT_W-1:0] i_logit_h,
    input  logic signed [ygbd_pkg::LOGIT_W-1:0] i_logit_object,
    input  logic signed [ygbd_pkg::LOGIT_W-1:0] i_logit_class,
    input  logic [ygbd_pkg::LABEL_W-1:0]        i_class_index,
    input  logic [ygbd_pkg::GRID_W-1:0]         i_grid_col,
    input  logic [ygbd_pkg::GRID_W-1:0]         i_grid_row,
    input  logic [ygbd_pkg::PICK_W-1:0]         i_anchor_pick,
    // box output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ygbd_pkg::COORD_W-1:0]        o_left,
    output logic [ygbd_pkg::COORD_W-1:0]        o_top,
    output logic [ygbd_pkg::COORD_W-1:0]        o_right,
    output logic [ygbd_pkg::COORD_W-1:0]        o_bottom,
    output logic [ygbd_pkg::SCORE_W-1:0]        o_score,
    output logic [ygbd_pkg::LABEL_W-1:0]        o_label,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ygbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ygbd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ygbd_pkg::*;

    localparam logic [COORD_W-1:0] IMG_W = COORD_W'(IMAGE_WIDTH);
    localparam logic [COORD_W-1:0] IMG_H = COORD_W'(IMAGE_HEIGHT);
    localparam logic [LABEL_W:0]   CLS_LIMIT = (LABEL_W+1)'(NUM_CLASSES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STRIDE_W-1:0] r_grid_stride;
    logic [ANCHOR_W-1:0] r_anchor_width_a, r_anchor_width_b, r_anchor_width_c;
    logic [ANCHOR_W-1:0] r_anchor_height_a, r_anchor_height_b, r_anchor_height_c;
    logic [SCORE_W-1:0]  r_score_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_stride     <= RST_GRID_STRIDE;
            r_anchor_width_a  <= RST_ANCHOR_WIDTH_A;
            r_anchor_width_b  <= RST_ANCHOR_WIDTH_B;
            r_anchor_width_c  <= RST_ANCHOR_WIDTH_C;
            r_anchor_height_a <= RST_ANCHOR_HEIGHT_A;
            r_anchor_height_b <= RST_ANCHOR_HEIGHT_B;
            r_anchor_height_c <= RST_ANCHOR_HEIGHT_C;
            r_score_threshold <= RST_SCORE_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_STRIDE:     r_grid_stride     <= i_cfg_data[STRIDE_W-1:0];
                CFG_ANCHOR_WIDTH_A:  r_anchor_width_a  <= i_cfg_data[ANCHOR_W-1:0];
                CFG_ANCHOR_WIDTH_B:  r_anchor_width_b  <= i_cfg_data[ANCHOR_W-1:0];
                CFG_ANCHOR_WIDTH_C:  r_anchor_width_c  <= i_cfg_data[ANCHOR_W-1:0];
                CFG_ANCHOR_HEIGHT_A: r_anchor_height_a <= i_cfg_data[ANCHOR_W-1:0];
                CFG_ANCHOR_HEIGHT_B: r_anchor_height_b <= i_cfg_data[ANCHOR_W-1:0];
                CFG_ANCHOR_HEIGHT_C: r_anchor_height_c <= i_cfg_data[ANCHOR_W-1:0];
                CFG_SCORE_THRESHOLD: r_score_threshold <= i_cfg_data[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when empty or when it moves on
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !r_v5 || !i_stall;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    // ------------------------------------------------------------------
    // Stage 1: filter, anchor select, sigmoid table lookups
    // ------------------------------------------------------------------
    logic [LOGIT_W-1:0]  in_logit [NUM_LOGITS];
    logic                keep;
    logic [ANCHOR_W-1:0] n_aw, n_ah;

    t_sig_pre            r1_pre [NUM_LOGITS];
    logic [LABEL_W-1:0]  r1_cls;
    logic [GRID_W-1:0]   r1_col, r1_row;
    logic [ANCHOR_W-1:0] r1_aw, r1_ah;

    assign in_logit[LG_X]   = i_logit_x;
    assign in_logit[LG_Y]   = i_logit_y;
    assign in_logit[LG_W]   = i_logit_w;
    assign in_logit[LG_H]   = i_logit_h;
    assign in_logit[LG_OBJ] = i_logit_object;
    assign in_logit[LG_CLS] = i_logit_class;

    // unused anchor code or unknown class gives no box
    assign keep = (i_anchor_pick != PICK_NONE) && ({1'b0, i_class_index} < CLS_LIMIT);

    always_comb begin
        case (i_anchor_pick)
            PICK_A: begin
                n_aw = r_anchor_width_a;
                n_ah = r_anchor_height_a;
            end
            PICK_B: begin
                n_aw = r_anchor_width_b;
                n_ah = r_anchor_height_b;
            end
            default: begin
                n_aw = r_anchor_width_c;
                n_ah = r_anchor_height_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            for (int i = 0; i < NUM_LOGITS; i++) begin
                r1_pre[i] <= sig_front(in_logit[i]);
            end
            r1_cls <= i_class_index;
            r1_col <= i_grid_col;
            r1_row <= i_grid_row;
            r1_aw  <= n_aw;
            r1_ah  <= n_ah;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: interpolate the six sigmoids
    // ------------------------------------------------------------------
    logic [15:0]         r2_sig [NUM_LOGITS];
    logic [LABEL_W-1:0]  r2_cls;
    logic [GRID_W-1:0]   r2_col, r2_row;
    logic [ANCHOR_W-1:0] r2_aw, r2_ah;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int i = 0; i < NUM_LOGITS; i++) begin
                r2_sig[i] <= sig_back(r1_pre[i]);
            end
            r2_cls <= r1_cls;
            r2_col <= r1_col;
            r2_row <= r1_row;
            r2_aw  <= r1_aw;
            r2_ah  <= r1_ah;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: score product, size squares, centre offsets in Q.16
    // ------------------------------------------------------------------
    logic signed [25:0]  n_ax, n_ay;
    logic [31:0]         r3_prod, r3_sqw, r3_sqh;
    logic signed [25:0]  r3_ax, r3_ay;
    logic [LABEL_W-1:0]  r3_cls;
    logic [ANCHOR_W-1:0] r3_aw, r3_ah;

    // 2s + grid - 0.5
    assign n_ax = $signed({8'b0, r2_sig[LG_X], 1'b0} + {2'b0, r2_col, 16'b0}
                          - {10'b0, HALF_Q16});
    assign n_ay = $signed({8'b0, r2_sig[LG_Y], 1'b0} + {2'b0, r2_row, 16'b0}
                          - {10'b0, HALF_Q16});

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_prod <= r2_sig[LG_OBJ] * r2_sig[LG_CLS];
            r3_sqw  <= r2_sig[LG_W] * r2_sig[LG_W];
            r3_sqh  <= r2_sig[LG_H] * r2_sig[LG_H];
            r3_ax   <= n_ax;
            r3_ay   <= n_ay;
            r3_cls  <= r2_cls;
            r3_aw   <= r2_aw;
            r3_ah   <= r2_ah;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round and test score, half sizes and centres in Q.32
    // ------------------------------------------------------------------
    logic [32:0]         score_rnd;
    logic [SCORE_W-1:0]  n_score;
    logic                pass;
    logic [41:0]         n_hw_half, n_hh_half;
    logic signed [33:0]  n_cxs, n_cys;

    logic [SCORE_W-1:0]  r4_score;
    logic [LABEL_W-1:0]  r4_cls;
    logic [42:0]         r4_hw, r4_hh;
    logic signed [49:0]  r4_cx, r4_cy;

    assign score_rnd = {1'b0, r3_prod} + {17'b0, HALF_Q16};
    assign n_score   = score_rnd[31:16];
    assign pass      = n_score > r_score_threshold;
    assign n_hw_half = r3_sqw * r3_aw;
    assign n_hh_half = r3_sqh * r3_ah;
    assign n_cxs     = r3_ax * $signed({1'b0, r_grid_stride});
    assign n_cys     = r3_ay * $signed({1'b0, r_grid_stride});

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_score <= n_score;
            r4_cls   <= r3_cls;
            r4_hw    <= {n_hw_half, 1'b0};
            r4_hh    <= {n_hh_half, 1'b0};
            r4_cx    <= {n_cxs, 16'b0};
            r4_cy    <= {n_cys, 16'b0};
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: corners, floor and clamp, output register
    // ------------------------------------------------------------------
    logic signed [50:0] lo_x, lo_y, hi_x, hi_y;

    assign lo_x = $signed({r4_cx[49], r4_cx}) - $signed({8'b0, r4_hw});
    assign hi_x = $signed({r4_cx[49], r4_cx}) + $signed({8'b0, r4_hw});
    assign lo_y = $signed({r4_cy[49], r4_cy}) - $signed({8'b0, r4_hh});
    assign hi_y = $signed({r4_cy[49], r4_cy}) + $signed({8'b0, r4_hh});

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            o_left   <= corner(lo_x, IMG_W);
            o_top    <= corner(lo_y, IMG_H);
            o_right  <= corner(hi_x, IMG_W);
            o_bottom <= corner(hi_y, IMG_H);
            o_score  <= r4_score;
            o_label  <= r4_cls;
        end
    end

    assign o_valid = r_v5;

    // ------------------------------------------------------------------
    // Stage valid bits; dropped candidates leave a bubble
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid && keep;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3 && pass;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `YG_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall), "input stalled with a free stage")
    `YG_ASSERT_NXT(a_drop_pick, i_clk, i_rst_n, (i_valid && !o_stall && (i_anchor_pick == PICK_NONE)), !r_v1, "unused anchor code entered the pipeline")
    `YG_ASSERT_IMP(a_box_order, i_clk, i_rst_n, o_valid, ((o_left <= o_right) && (o_top <= o_bottom) && (o_right <= IMG_W) && (o_bottom <= IMG_H)), "box corners out of order or range")
    `YG_ASSERT_IMP(a_label_range, i_clk, i_rst_n, o_valid, ({1'b0, o_label} < CLS_LIMIT), "box emitted for unknown class")

endmodule

[dv/yolo_grid_box_decode_tb.sv]
// ----------------------------------------------------------------------------
// yolo_grid_box_decode_tb
// Self-checking bench for the grid box decoder. Candidates are driven on the
// valid/stall input, and each transfer is decoded by a local fixed-point
// predictor. Predicted boxes queue up and are matched in order against the
// output transfers. A directed table comes first. Randomized phases follow
// under several register settings, with random idling on both sides and a
// long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yolo_grid_box_decode_tb;

    import ygbd_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 12;      // pipeline is 5 deep, plus margin
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 9;
    localparam int SIG_STEPS     = 32;
    localparam int HOLD_OFF      = 80;

    localparam logic [LOGIT_W-1:0] LOGIT_MAX = 16'h7FFF;
    localparam logic [LOGIT_W-1:0] LOGIT_MIN = 16'h8000;

    typedef struct packed {
        logic [LOGIT_W-1:0]  logit_x;
        logic [LOGIT_W-1:0]  logit_y;
        logic [LOGIT_W-1:0]  logit_w;
        logic [LOGIT_W-1:0]  logit_h;
        logic [LOGIT_W-1:0]  logit_object;
        logic [LOGIT_W-1:0]  logit_class;
        logic [LABEL_W-1:0]  cls;
        logic [GRID_W-1:0]   col;
        logic [GRID_W-1:0]   row;
        logic [PICK_W-1:0]   pick;
    } cand_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [SCORE_W-1:0] score;
        logic [LABEL_W-1:0] label;
    } box_t;

    typedef struct packed {
        logic [STRIDE_W-1:0]         stride;
        logic [2:0][ANCHOR_W-1:0]    aw;
        logic [2:0][ANCHOR_W-1:0]    ah;
        logic [SCORE_W-1:0]          thr;
    } box_cfg_t;

    // Directed rows: checked by the predictor, known to be dropped, or fixed
    typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_FIXED} row_kind_e;

    typedef struct packed {
        cand_t     c;
        row_kind_e kind;
        box_t      want;
    } dir_row_t;

    // DUT signals
    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       o_stall;
    logic signed [LOGIT_W-1:0]  i_logit_x      = '0;
    logic signed [LOGIT_W-1:0]  i_logit_y      = '0;
    logic signed [LOGIT_W-1:0]  i_logit_w      = '0;
    logic signed [LOGIT_W-1:0]  i_logit_h      = '0;
    logic signed [LOGIT_W-1:0]  i_logit_object = '0;
    logic signed [LOGIT_W-1:0]  i_logit_class  = '0;
    logic [LABEL_W-1:0]         i_class_index  = '0;
    logic [GRID_W-1:0]          i_grid_col     = '0;
    logic [GRID_W-1:0]          i_grid_row     = '0;
    logic [PICK_W-1:0]          i_anchor_pick  = '0;
    logic                       o_valid;
    logic                       i_stall        = 1'b0;
    logic [COORD_W-1:0]         o_left;
    logic [COORD_W-1:0]         o_top;
    logic [COORD_W-1:0]         o_right;
    logic [COORD_W-1:0]         o_bottom;
    logic [SCORE_W-1:0]         o_score;
    logic [LABEL_W-1:0]         o_label;
    logic                       i_cfg_valid    = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data     = '0;

    // Bench state
    box_t        pending_boxes[$];
    dir_row_t    directed_rows[$];
    box_cfg_t    cfg_now;
    bit          no_idle    = 1'b0;
    int          sink_hold  = 0;
    int          errors     = 0;
    int unsigned cycles     = 0;

    // round(65536 * sigmoid(k/4)), k = 0..32
    int unsigned sig_points [0:32] = '{
        32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
        57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
        64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
        65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
        65514
    };

    yolo_grid_box_decode dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_logit_x      (i_logit_x),
        .i_logit_y      (i_logit_y),
        .i_logit_w      (i_logit_w),
        .i_logit_h      (i_logit_h),
        .i_logit_object (i_logit_object),
        .i_logit_class  (i_logit_class),
        .i_class_index  (i_class_index),
        .i_grid_col     (i_grid_col),
        .i_grid_row     (i_grid_row),
        .i_anchor_pick  (i_anchor_pick),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_left         (o_left),
        .o_top          (o_top),
        .o_right        (o_right),
        .o_bottom       (o_bottom),
        .o_score        (o_score),
        .o_label        (o_label),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Table sigmoid of a Q4.12 logit, Q0.16 result
    function automatic int unsigned sigmoid_q16(input logic [LOGIT_W-1:0] raw);
        int unsigned mag;
        int unsigned k;
        int unsigned v;
        mag = raw[15] ? (32'h10000 - 32'(raw)) : 32'(raw);
        k   = mag >> 10;
        if (k >= SIG_STEPS) begin
            v = sig_points[SIG_STEPS];
        end else begin
            v = sig_points[k] +
                (((sig_points[k + 1] - sig_points[k]) * (mag & 1023) + 512) >> 10);
        end
        return raw[15] ? (32'h10000 - v) : v;
    endfunction

    // Floor of a Q.32 coordinate, clamped to [0, lim]
    function automatic logic [COORD_W-1:0] clamp_corner(input longint q, input int lim);
        longint whole;
        if (q < 0) return '0;
        whole = q >>> 32;
        if (whole > lim) whole = lim;
        return COORD_W'(whole);
    endfunction

    // Box that the current settings give for one candidate; 0 when dropped
    function automatic bit decode_box(input cand_t c, output box_t b);
        longint aw;
        longint ah;
        longint s_obj;
        longint s_cls;
        longint score;
        longint sx;
        longint sy;
        longint sw;
        longint sh;
        longint cx;
        longint cy;
        longint hw;
        longint hh;
        b = '0;
        if (c.pick == PICK_NONE || c.cls >= NUM_CLASSES) return 1'b0;
        aw    = longint'(cfg_now.aw[c.pick]);
        ah    = longint'(cfg_now.ah[c.pick]);
        s_obj = longint'(sigmoid_q16(c.logit_object));
        s_cls = longint'(sigmoid_q16(c.logit_class));
        score = (s_obj * s_cls + 32768) >>> 16;
        if (score <= longint'(cfg_now.thr)) return 1'b0;
        sx = longint'(sigmoid_q16(c.logit_x));
        sy = longint'(sigmoid_q16(c.logit_y));
        sw = longint'(sigmoid_q16(c.logit_w));
        sh = longint'(sigmoid_q16(c.logit_h));
        // centre (2s - 0.5 + cell) * stride, half size (2s)^2 * anchor / 2, all Q.32
        cx = (2 * sx + longint'(c.col) * 65536 - 32768) * longint'(cfg_now.stride) * 65536;
        cy = (2 * sy + longint'(c.row) * 65536 - 32768) * longint'(cfg_now.stride) * 65536;
        hw = 2 * sw * sw * aw;
        hh = 2 * sh * sh * ah;
        b.left   = clamp_corner(cx - hw, IMAGE_WIDTH);
        b.top    = clamp_corner(cy - hh, IMAGE_HEIGHT);
        b.right  = clamp_corner(cx + hw, IMAGE_WIDTH);
        b.bottom = clamp_corner(cy + hh, IMAGE_HEIGHT);
        b.score  = SCORE_W'(score);
        b.label  = c.cls;
        return 1'b1;
    endfunction

    // Register write as the block applies it: high bits are dropped
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GRID_STRIDE:     cfg_now.stride     = data[STRIDE_W-1:0];
            CFG_ANCHOR_WIDTH_A:  cfg_now.aw[PICK_A] = data[ANCHOR_W-1:0];
            CFG_ANCHOR_WIDTH_B:  cfg_now.aw[PICK_B] = data[ANCHOR_W-1:0];
            CFG_ANCHOR_WIDTH_C:  cfg_now.aw[PICK_C] = data[ANCHOR_W-1:0];
            CFG_ANCHOR_HEIGHT_A: cfg_now.ah[PICK_A] = data[ANCHOR_W-1:0];
            CFG_ANCHOR_HEIGHT_B: cfg_now.ah[PICK_B] = data[ANCHOR_W-1:0];
            CFG_ANCHOR_HEIGHT_C: cfg_now.ah[PICK_C] = data[ANCHOR_W-1:0];
            CFG_SCORE_THRESHOLD: cfg_now.thr        = data[SCORE_W-1:0];
            default: ;
        endcase
    endfunction

    // Append a predicted box at the tail of the expected queue
    function automatic void queue_box(input box_t b);
        pending_boxes.insert(pending_boxes.size(), b);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic cand_t cand(input logic [LOGIT_W-1:0] x, y, w, h, obj, cl,
                                   input logic [LABEL_W-1:0] cls,
                                   input logic [GRID_W-1:0] col, row,
                                   input logic [PICK_W-1:0] pick);
        return {x, y, w, h, obj, cl, cls, col, row, pick};
    endfunction

    function automatic void add_row(input row_kind_e kind, input cand_t c, input box_t want);
        directed_rows.insert(directed_rows.size(), {c, kind, want});
    endfunction

    // Mostly within +-4.0 where the table slopes, sometimes anywhere or at the rails
    function automatic logic [LOGIT_W-1:0] rand_logit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return LOGIT_W'($urandom_range(0, 32768) - 16384);
        if (r < 90) return LOGIT_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return LOGIT_MAX;
            1:       return LOGIT_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Objectness and class lean positive so that enough boxes pass
    function automatic logic [LOGIT_W-1:0] rand_score_logit();
        if ($urandom_range(0, 99) < 60) return LOGIT_W'($urandom_range(0, 24000));
        return rand_logit();
    endfunction

    function automatic cand_t rand_candidate();
        cand_t c;
        c.logit_x      = rand_logit();
        c.logit_y      = rand_logit();
        c.logit_w      = rand_logit();
        c.logit_h      = rand_logit();
        c.logit_object = rand_score_logit();
        c.logit_class  = rand_score_logit();
        if ($urandom_range(0, 99) < 85) begin
            c.cls  = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
            c.pick = PICK_W'($urandom_range(PICK_A, PICK_C));
        end else begin
            // noise: any class number, any selector
            c.cls  = LABEL_W'($urandom);
            c.pick = PICK_W'($urandom);
        end
        c.col = ($urandom_range(0, 3) == 0) ? GRID_W'($urandom) : GRID_W'($urandom_range(0, 90));
        c.row = ($urandom_range(0, 3) == 0) ? GRID_W'($urandom) : GRID_W'($urandom_range(0, 90));
        return c;
    endfunction

    // One candidate transfer; returns at the edge where it is taken
    task automatic send_candidate(input cand_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_logit_x      <= c.logit_x;
        i_logit_y      <= c.logit_y;
        i_logit_w      <= c.logit_w;
        i_logit_h      <= c.logit_h;
        i_logit_object <= c.logit_object;
        i_logit_class  <= c.logit_class;
        i_class_index  <= c.cls;
        i_grid_col     <= c.col;
        i_grid_row     <= c.row;
        i_anchor_pick  <= c.pick;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Register write; the caller lowers valid after the last one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_reg(idx, data);
    endtask

    // Write all eight registers from a random start, junk in the unused high bits
    task automatic program_setting(input box_cfg_t s);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] value;
        int start;
        start = $urandom_range(0, 7);
        for (int r = 0; r < (1 << CFG_IDX_W); r++) begin
            idx  = CFG_IDX_W'(r + start);
            junk = CFG_DATA_W'($urandom);
            case (idx)
                CFG_GRID_STRIDE:     value = {junk[15:STRIDE_W], s.stride};
                CFG_ANCHOR_WIDTH_A:  value = {junk[15:ANCHOR_W], s.aw[PICK_A]};
                CFG_ANCHOR_WIDTH_B:  value = {junk[15:ANCHOR_W], s.aw[PICK_B]};
                CFG_ANCHOR_WIDTH_C:  value = {junk[15:ANCHOR_W], s.aw[PICK_C]};
                CFG_ANCHOR_HEIGHT_A: value = {junk[15:ANCHOR_W], s.ah[PICK_A]};
                CFG_ANCHOR_HEIGHT_B: value = {junk[15:ANCHOR_W], s.ah[PICK_B]};
                CFG_ANCHOR_HEIGHT_C: value = {junk[15:ANCHOR_W], s.ah[PICK_C]};
                default:             value = s.thr;
            endcase
            cfg_write(idx, value);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending and let the pipeline empty, dropped candidates included
    task automatic wait_for_boxes();
        i_valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall per box, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : box_sink
        int n;
        forever begin
            if (sink_hold > 0) begin
                n         = sink_hold;
                sink_hold = 0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1 && sink_hold == 0);
        end
    end

    // Match each box transfer against the oldest prediction
    always @(posedge i_clk) begin : box_check
        box_t want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t: unexpected box left %0d top %0d right %0d bottom %0d",
                         $time, o_left, o_top, o_right, o_bottom);
                $display("%0t: unexpected box score %0d label %0d",
                         $time, o_score, o_label);
                errors++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("left",   want.left,   o_left);
                check_field("top",    want.top,    o_top);
                check_field("right",  want.right,  o_right);
                check_field("bottom", want.bottom, o_bottom);
                check_field("score",  want.score,  o_score);
                check_field("label",  want.label,  o_label);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        box_cfg_t setting;
        cand_t    c;
        box_t     b;
        int       budget;
        int       sent;
        int       w;

        cfg_now.stride     = RST_GRID_STRIDE;
        cfg_now.aw[PICK_A] = RST_ANCHOR_WIDTH_A;
        cfg_now.aw[PICK_B] = RST_ANCHOR_WIDTH_B;
        cfg_now.aw[PICK_C] = RST_ANCHOR_WIDTH_C;
        cfg_now.ah[PICK_A] = RST_ANCHOR_HEIGHT_A;
        cfg_now.ah[PICK_B] = RST_ANCHOR_HEIGHT_B;
        cfg_now.ah[PICK_C] = RST_ANCHOR_HEIGHT_C;
        cfg_now.thr        = RST_SCORE_THRESHOLD;

        // Directed table, run at the reset register values
        // zero logits: score lands exactly on the default threshold
        add_row(ROW_QUIET, cand(0, 0, 0, 0, 0, 0, 0, 0, 0, PICK_A), '0);
        // saturated logits at the far cell: every corner pinned to the image edge
        add_row(ROW_FIXED, cand(LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX,
                                79, 255, 255, PICK_A),
                {12'd640, 12'd640, 12'd640, 12'd640, 16'd65492, 8'd79});
        // most negative logits: score rounds to zero
        add_row(ROW_QUIET, cand(LOGIT_MIN, LOGIT_MIN, LOGIT_MIN, LOGIT_MIN, LOGIT_MIN, LOGIT_MIN,
                                0, 0, 0, PICK_C), '0);
        // unused anchor selector
        add_row(ROW_QUIET, cand(LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX,
                                5, 3, 3, PICK_NONE), '0);
        // class numbers past the last class
        add_row(ROW_QUIET, cand(LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX,
                                NUM_CLASSES, 3, 3, PICK_B), '0);
        add_row(ROW_QUIET, cand(LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX,
                                255, 3, 3, PICK_C), '0);
        // negative centre at the origin cell clamps to zero
        add_row(ROW_MODEL, cand(LOGIT_MIN, LOGIT_MIN, LOGIT_MIN, LOGIT_MIN, LOGIT_MAX, LOGIT_MAX,
                                0, 0, 0, PICK_A), '0);
        // sign boundary and table index edges
        add_row(ROW_MODEL, cand(-1, 1, 0, -1, 12000, 9000, 3, 40, 40, PICK_B), '0);
        add_row(ROW_MODEL, cand(1024, 1023, 31744, -31744, 16384, 16383, 17, 79, 1, PICK_C), '0);
        add_row(ROW_MODEL, cand(16'h8001, LOGIT_MAX, 8192, 4096, LOGIT_MAX, 4096,
                                79, 1, 79, PICK_A), '0);
        add_row(ROW_MODEL, cand(2000, -3000, 5000, 6000, 20000, 20000, 42, 128, 64, PICK_B), '0);
        add_row(ROW_MODEL, cand(0, 0, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX, LOGIT_MAX,
                                1, 10, 10, PICK_C), '0);
        // scores around the threshold
        add_row(ROW_MODEL, cand(300, -300, -2000, 2000, 4000, 0, 60, 20, 30, PICK_A), '0);
        add_row(ROW_MODEL, cand(-5000, 5000, 100, -100, -4000, 8000, 2, 77, 5, PICK_B), '0);
        add_row(ROW_MODEL, cand(700, 800, 900, 1000, LOGIT_MIN, LOGIT_MAX, 9, 9, 9, PICK_C), '0);
        add_row(ROW_MODEL, cand(LOGIT_MAX, LOGIT_MIN, -8192, 12288, 30000, 30000,
                                78, 255, 0, PICK_A), '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_candidate(directed_rows[i].c);
            case (directed_rows[i].kind)
                ROW_FIXED: queue_box(directed_rows[i].want);
                ROW_MODEL: if (decode_box(directed_rows[i].c, b)) queue_box(b);
                default: ;  // dropped candidate, no box
            endcase
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_boxes();
            setting.stride = STRIDE_W'($urandom_range(1, 64));
            for (int a = 0; a < 3; a++) begin
                setting.aw[a] = ANCHOR_W'($urandom_range(0, 1023));
                setting.ah[a] = ANCHOR_W'($urandom_range(0, 1023));
            end
            setting.thr = SCORE_W'($urandom_range(0, 50000));
            budget  = 188;
            no_idle = ($urandom_range(0, 2) == 0);
            case (p)
                0: begin
                    // zero stride and zero anchors: boxes collapse onto the origin
                    setting.stride = '0;
                    setting.aw     = '0;
                    setting.ah     = '0;
                    setting.thr    = '0;
                    budget         = 150;
                    no_idle        = 1'b0;
                end
                1: begin
                    setting.stride = '1;
                    setting.aw     = '1;
                    setting.ah     = '1;
                    setting.thr    = '0;
                    budget         = 150;
                    no_idle        = 1'b1;
                end
                2: begin
                    // threshold above any reachable score: nothing comes out
                    setting.stride = 7'd64;
                    setting.aw     = '1;
                    setting.ah     = '0;
                    setting.thr    = '1;
                    budget         = 60;
                end
                3: begin
                    setting.stride = 7'd1;
                    setting.thr    = 16'd1;
                    budget         = 150;
                    no_idle        = 1'b1;
                end
                default: ;
            endcase
            program_setting(setting);

            sent = 0;
            while (sent < budget) begin
                // output held off while candidates keep coming
                if (p == 3 && (sent == 0 || sent == budget / 2)) sink_hold = HOLD_OFF;
                // sender pauses until every box is out
                if (p == 5 && sent == budget / 2) wait_for_boxes();
                c = rand_candidate();
                send_candidate(c);
                if (decode_box(c, b)) queue_box(b);
                sent++;
            end
        end

        // Drain and report
        i_valid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && pending_boxes.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_boxes.size() != 0) begin
            $display("%0t: %0d expected boxes never arrived", $time, pending_boxes.size());
            errors++;
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
